[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check on clk, off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// implication form of the clocked check
`define ASSERT_IMPLIES(label, pre, post, msg) \
    `ASSERT_CLK(label, (pre) |-> (post), msg)

`endif

[rtl/psv_pkg.sv]
`default_nettype none

package psv_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    localparam int EDGE_LIMIT_W   = 40;
    localparam int NORMAL_LIMIT_W = 63;
    localparam int PLANE_LIMIT_W  = 53;
    localparam int CFG_DATA_W     = 63;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_LIMIT  = 2'd2;

    // a cross term's magnitude is squared as 32 bits; a larger one saturates the normal test
    localparam int          SQ_W    = 33;
    localparam logic [31:0] SAT_MAG = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

[rtl/point_set_volume_test.sv]
// result_valid rises from finish on a set's last point, once the output register can take it
// edge, normal and plane tests run through multiply, drain and check; the origin or a point of a
//   flagged set goes straight to finish; one shared multiplier gives one product per cycle
// point_stall stays high while a point is in the sequencer or its word waits on result_stall
// reset: asynchronous, active low; clears the set state, the limits and the output word
`default_nettype none
`include "assert_macros.svh"

module point_set_volume_test
    import psv_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          point_valid,
    output logic                          point_stall,
    input  logic signed [COORD_WIDTH-1:0] x,
    input  logic signed [COORD_WIDTH-1:0] y,
    input  logic signed [COORD_WIDTH-1:0] z,
    input  logic                          last_point,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          spans_volume,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int EW     = COORD_WIDTH + 1;
    localparam int CW     = 2 * COORD_WIDTH + 3;
    localparam int MA     = (CW > SQ_W) ? CW : SQ_W;
    localparam int MB     = (EW > SQ_W) ? EW : SQ_W;
    localparam int MW     = (CW > SQ_W) ? CW : SQ_W;
    localparam int PW     = MA + MB;
    localparam int ACC_W  = PW + 2;
    localparam int CMP_W  = (ACC_W > 64) ? ACC_W : 64;

    localparam logic [3:0] VEC_LAST    = 4'd2;
    localparam logic [3:0] NORMAL_LAST = 4'd8;

    typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DRAIN, ST_CHECK, ST_FINISH} state_t;
    typedef enum logic [1:0] {PH_EDGE, PH_NORMAL, PH_DOT} phase_t;
    typedef enum logic [1:0] {TGT_ACC, TGT_CX, TGT_CY, TGT_CZ} tgt_t;

    state_t state_reg;
    logic [3:0] step_reg;
    logic pv_reg;
    logic have_origin_reg;
    logic have_edge_reg;
    logic have_normal_reg;
    logic found_volume_reg;
    logic result_valid_reg;
    logic spans_volume_reg;

    logic [EDGE_LIMIT_W-1:0]   edge_limit_reg;
    logic [NORMAL_LIMIT_W-1:0] normal_limit_reg;
    logic [PLANE_LIMIT_W-1:0]  plane_limit_reg;

    logic signed [COORD_WIDTH-1:0] origin_reg [3];
    logic signed [EW-1:0]          e_reg      [3];
    logic signed [EW-1:0]          fe_reg     [3];
    logic signed [CW-1:0]          n_reg      [3];
    logic signed [CW-1:0]          cx_reg;
    logic signed [CW-1:0]          cy_reg;
    logic signed [CW-1:0]          cz_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [PW-1:0]          prod_reg;
    tgt_t                          tgt_reg;
    logic                          neg_reg;
    logic                          sat_reg;
    logic                          last_reg;

    phase_t phase;
    logic [3:0] last_step;
    logic accept;
    logic result_load;
    logic signed [MA-1:0] a_op;
    logic signed [MB-1:0] b_op;
    logic signed [PW-1:0] prod_next;
    tgt_t tgt;
    logic neg;
    logic sq;
    logic signed [EW-1:0] e_sel;
    logic signed [CW-1:0] n_sel;
    logic signed [CW-1:0] c_sel;
    logic [CW-1:0] c_mag;
    logic [MW-1:0] c_mag_ext;
    logic sat_now;
    logic [SQ_W-1:0] sq_op;
    logic [ACC_W-1:0] acc_mag;
    logic [CMP_W-1:0] acc_cmp;
    logic pass;
    logic signed [CW-1:0] prod_c;

    assign point_stall  = (state_reg != ST_IDLE);
    assign accept       = point_valid && !point_stall;
    assign result_valid = result_valid_reg;
    assign spans_volume = spans_volume_reg;
    // closing word goes out once the output register is free or being emptied
    assign result_load  = (state_reg == ST_FINISH) && last_reg
                          && (!result_valid_reg || !result_stall);

    always_comb
    begin
        if (!have_edge_reg)
        begin
            phase = PH_EDGE;
        end
        else if (!have_normal_reg)
        begin
            phase = PH_NORMAL;
        end
        else
        begin
            phase = PH_DOT;
        end
        last_step = (phase == PH_NORMAL) ? NORMAL_LAST : VEC_LAST;
    end

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (step_reg)
            4'd0:    begin e_sel = e_reg[0]; n_sel = n_reg[0]; end
            4'd1:    begin e_sel = e_reg[1]; n_sel = n_reg[1]; end
            default: begin e_sel = e_reg[2]; n_sel = n_reg[2]; end
        endcase
        unique case (step_reg)
            4'd6:    c_sel = cx_reg;
            4'd7:    c_sel = cy_reg;
            default: c_sel = cz_reg;
        endcase
        c_mag     = c_sel[CW-1] ? CW'(-c_sel) : CW'(c_sel);
        c_mag_ext = MW'(c_mag);
        sat_now   = (c_mag_ext > MW'(SAT_MAG));
        sq_op     = {1'b0, c_mag_ext[SQ_W-2:0]};

        a_op = '0;
        b_op = '0;
        tgt  = TGT_ACC;
        neg  = 1'b0;
        sq   = 1'b0;
        unique case (phase)
            PH_EDGE:
            begin
                a_op = MA'(e_sel);
                b_op = MB'(e_sel);
            end
            PH_DOT:
            begin
                a_op = MA'(n_sel);
                b_op = MB'(e_sel);
            end
            default:
            begin
                unique case (step_reg)
                    4'd0: begin a_op = MA'(fe_reg[1]); b_op = MB'(e_reg[2]); tgt = TGT_CX; end
                    4'd1:
                    begin
                        a_op = MA'(fe_reg[2]); b_op = MB'(e_reg[1]); tgt = TGT_CX; neg = 1'b1;
                    end
                    4'd2: begin a_op = MA'(fe_reg[2]); b_op = MB'(e_reg[0]); tgt = TGT_CY; end
                    4'd3:
                    begin
                        a_op = MA'(fe_reg[0]); b_op = MB'(e_reg[2]); tgt = TGT_CY; neg = 1'b1;
                    end
                    4'd4: begin a_op = MA'(fe_reg[0]); b_op = MB'(e_reg[1]); tgt = TGT_CZ; end
                    4'd5:
                    begin
                        a_op = MA'(fe_reg[1]); b_op = MB'(e_reg[0]); tgt = TGT_CZ; neg = 1'b1;
                    end
                    default:
                    begin
                        // squares of the cross terms, zero-extended magnitudes
                        a_op = signed'(MA'(sq_op));
                        b_op = signed'(MB'(sq_op));
                        sq   = 1'b1;
                    end
                endcase
            end
        endcase
        prod_next = a_op * b_op;
        prod_c    = CW'(prod_reg);
    end

    always_comb
    begin
        acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        acc_cmp = CMP_W'(acc_mag);
        unique case (phase)
            PH_EDGE:   pass = (acc_cmp > CMP_W'(edge_limit_reg));
            PH_NORMAL: pass = sat_reg || (acc_cmp > CMP_W'(normal_limit_reg));
            default:   pass = (acc_cmp > CMP_W'(plane_limit_reg));
        endcase
    end

    // sequencer, limit registers, set flags and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            pv_reg           <= 1'b0;
            have_origin_reg  <= 1'b0;
            have_edge_reg    <= 1'b0;
            have_normal_reg  <= 1'b0;
            found_volume_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            spans_volume_reg <= 1'b0;
            edge_limit_reg   <= '0;
            normal_limit_reg <= '0;
            plane_limit_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_EDGE_LIMIT:   edge_limit_reg   <= cfg_data[EDGE_LIMIT_W-1:0];
                    REG_NORMAL_LIMIT: normal_limit_reg <= cfg_data[NORMAL_LIMIT_W-1:0];
                    REG_PLANE_LIMIT:  plane_limit_reg  <= cfg_data[PLANE_LIMIT_W-1:0];
                    default:          ;
                endcase
            end

            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    pv_reg <= 1'b0;
                    if (accept)
                    begin
                        step_reg <= '0;
                        if (!have_origin_reg)
                        begin
                            have_origin_reg <= 1'b1;
                            state_reg       <= ST_FINISH;
                        end
                        else if (found_volume_reg)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    pv_reg   <= 1'b1;
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == last_step)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    pv_reg    <= 1'b0;
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (pass)
                    begin
                        unique case (phase)
                            PH_EDGE:   have_edge_reg    <= 1'b1;
                            PH_NORMAL: have_normal_reg  <= 1'b1;
                            default:   found_volume_reg <= 1'b1;
                        endcase
                    end
                    state_reg <= ST_FINISH;
                end
                default:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (result_load)
                    begin
                        spans_volume_reg <= found_volume_reg;
                        have_origin_reg  <= 1'b0;
                        have_edge_reg    <= 1'b0;
                        have_normal_reg  <= 1'b0;
                        found_volume_reg <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // datapath: origin, edge, first edge, normal, cross terms and accumulator
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= last_point;
            if (!have_origin_reg)
            begin
                origin_reg[0] <= x;
                origin_reg[1] <= y;
                origin_reg[2] <= z;
            end
            e_reg[0] <= EW'(x) - EW'(origin_reg[0]);
            e_reg[1] <= EW'(y) - EW'(origin_reg[1]);
            e_reg[2] <= EW'(z) - EW'(origin_reg[2]);
            acc_reg  <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            cz_reg   <= '0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            if (pv_reg)
            begin
                case (tgt_reg)
                    TGT_ACC: acc_reg <= acc_reg + ACC_W'(prod_reg);
                    TGT_CX:  cx_reg  <= neg_reg ? cx_reg - prod_c : cx_reg + prod_c;
                    TGT_CY:  cy_reg  <= neg_reg ? cy_reg - prod_c : cy_reg + prod_c;
                    default: cz_reg  <= neg_reg ? cz_reg - prod_c : cz_reg + prod_c;
                endcase
            end
            if (state_reg == ST_MUL)
            begin
                prod_reg <= prod_next;
                tgt_reg  <= tgt;
                neg_reg  <= neg;
                if (sq && sat_now)
                begin
                    sat_reg <= 1'b1;
                end
            end
            if (state_reg == ST_CHECK && pass)
            begin
                if (phase == PH_EDGE)
                begin
                    fe_reg[0] <= e_reg[0];
                    fe_reg[1] <= e_reg[1];
                    fe_reg[2] <= e_reg[2];
                end
                if (phase == PH_NORMAL)
                begin
                    n_reg[0] <= cx_reg;
                    n_reg[1] <= cy_reg;
                    n_reg[2] <= cz_reg;
                end
            end
        end
    end

    `ASSERT_IMPLIES(busy_stalls_a, state_reg != ST_IDLE, point_stall,
        "point taken while sequencer busy")
    `ASSERT_IMPLIES(result_from_finish_a, $rose(result_valid_reg),
        $past(state_reg == ST_FINISH), "result word raised outside finish")
    `ASSERT_IMPLIES(flag_order_a, have_normal_reg, have_edge_reg && have_origin_reg,
        "normal found without edge or origin")
    `ASSERT_IMPLIES(volume_needs_normal_a, found_volume_reg, have_normal_reg,
        "volume flagged without a normal")

endmodule

`default_nettype wire

[dv/point_set_volume_checker.sv]
`timescale 1ns / 100ps

module point_set_volume_checker
    import psv_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          point_valid,
    input  logic                          point_stall,
    input  logic signed [COORD_WIDTH_DEF-1:0] x,
    input  logic signed [COORD_WIDTH_DEF-1:0] y,
    input  logic signed [COORD_WIDTH_DEF-1:0] z,
    input  logic                          last_point,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic                          spans_volume,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output int                            errors,
    output int                            pending
);

    localparam int CW = COORD_WIDTH_DEF;

    logic [EDGE_LIMIT_W-1:0]   edge_lim;
    logic [NORMAL_LIMIT_W-1:0] normal_lim;
    logic [PLANE_LIMIT_W-1:0]  plane_lim;

    logic signed [CW-1:0]   org [3];
    logic signed [CW:0]     fedge [3];
    logic signed [2*CW+2:0] nrm [3];
    logic got_origin;
    logic got_edge;
    logic got_normal;
    logic in_volume;

    // one flag per set whose last point went in and whose word has not come out
    logic volume_flags_due [$];
    int   err_count = 0;

    assign errors  = err_count;
    assign pending = volume_flags_due.size();

    task automatic report(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        err_count++;
    endtask

    task automatic clear_set();
        for (int i = 0; i < 3; i++)
        begin
            org[i]   = '0;
            fedge[i] = '0;
            nrm[i]   = '0;
        end
        got_origin = 1'b0;
        got_edge   = 1'b0;
        got_normal = 1'b0;
        in_volume  = 1'b0;
    endtask

    // square of a cross term, pinned to all ones once the term passes 32 bits
    function automatic logic [63:0] sat_square(input longint v);
        logic [63:0] m;
        m = (v < 0) ? -v : v;
        if (m > {32'h0, SAT_MAG})
            return '1;
        return m * m;
    endfunction

    task automatic absorb_point(input logic signed [CW-1:0] px, py, pz, input logic last);
        logic signed [CW:0] d [3];
        longint      c [3];
        logic [63:0] len;
        logic [65:0] msum;
        logic [63:0] cross_mag;
        longint      dot;
        logic [63:0] dot_mag;
        if (!got_origin)
        begin
            org[0] = px;
            org[1] = py;
            org[2] = pz;
            got_origin = 1'b1;
        end
        else if (!in_volume)
        begin
            d[0] = px - org[0];
            d[1] = py - org[1];
            d[2] = pz - org[2];
            if (!got_edge)
            begin
                len = longint'(d[0]) * longint'(d[0]) + longint'(d[1]) * longint'(d[1])
                    + longint'(d[2]) * longint'(d[2]);
                if (len > edge_lim)
                begin
                    for (int i = 0; i < 3; i++)
                        fedge[i] = d[i];
                    got_edge = 1'b1;
                end
            end
            else if (!got_normal)
            begin
                c[0] = longint'(fedge[1]) * longint'(d[2]) - longint'(fedge[2]) * longint'(d[1]);
                c[1] = longint'(fedge[2]) * longint'(d[0]) - longint'(fedge[0]) * longint'(d[2]);
                c[2] = longint'(fedge[0]) * longint'(d[1]) - longint'(fedge[1]) * longint'(d[0]);
                msum = sat_square(c[0]) + sat_square(c[1]) + sat_square(c[2]);
                cross_mag = (msum[65:64] != 2'b00) ? '1 : msum[63:0];
                if (cross_mag > normal_lim)
                begin
                    for (int i = 0; i < 3; i++)
                        nrm[i] = c[i];
                    got_normal = 1'b1;
                end
            end
            else
            begin
                dot = longint'(nrm[0]) * longint'(d[0]) + longint'(nrm[1]) * longint'(d[1])
                    + longint'(nrm[2]) * longint'(d[2]);
                dot_mag = (dot < 0) ? -dot : dot;
                if (dot_mag > plane_lim)
                    in_volume = 1'b1;
            end
        end
        if (last)
        begin
            volume_flags_due = {volume_flags_due, in_volume};
            clear_set();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_lim   = '0;
            normal_lim = '0;
            plane_lim  = '0;
            clear_set();
            volume_flags_due.delete();
        end
        else
        begin
            // a word leaving now belongs to a set closed at an earlier edge
            if (result_valid && !result_stall)
            begin
                if (volume_flags_due.size() == 0)
                    report($sformatf("result word (spans_volume=%b) with no set closed",
                                     spans_volume));
                else if (spans_volume !== volume_flags_due[0])
                    report($sformatf("spans_volume got %b expected %b",
                                     spans_volume, volume_flags_due[0]));
                if (volume_flags_due.size() != 0)
                    void'(volume_flags_due.pop_front());
            end
            if (point_valid && !point_stall)
                absorb_point(x, y, z, last_point);
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_EDGE_LIMIT:   edge_lim   = cfg_data[EDGE_LIMIT_W-1:0];
                    REG_NORMAL_LIMIT: normal_lim = cfg_data[NORMAL_LIMIT_W-1:0];
                    REG_PLANE_LIMIT:  plane_lim  = cfg_data[PLANE_LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[dv/tb_point_set_volume_test.sv]
`timescale 1ns / 100ps

module tb_point_set_volume_test;
    import psv_pkg::*;

    localparam int CW            = COORD_WIDTH_DEF;
    localparam int CYCLE_LIMIT   = 900_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 400;
    localparam int PHASES        = 7;
    localparam int PHASE_POINTS  = 265;
    localparam int ZERO_PHASE    = 0;
    localparam int FULL_PHASE    = 1;

    // index with no register behind it, writes must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   point_valid;
    logic                   point_stall;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [CW-1:0]   z;
    logic                   last_point;
    logic                   result_valid;
    logic                   result_stall;
    logic                   spans_volume;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     errors;
    int                     pending;

    int unsigned cycle_count = 0;
    int          points_sent = 0;
    int          hold_req    = 0;
    logic        quiet       = 1'b0;

    point_set_volume_test u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .x            (x),
        .y            (y),
        .z            (z),
        .last_point   (last_point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .spans_volume (spans_volume),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    point_set_volume_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .x            (x),
        .y            (y),
        .z            (z),
        .last_point   (last_point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .spans_volume (spans_volume),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int srand(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (quiet || sel < 45)
            return 0;
        if (sel < 85)
            return $urandom_range(1, 3);
        if (sel < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // coordinates come in as int and are cut to the port width
    task automatic send_point(input int px, py, pz, input logic last);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            point_valid <= 1'b0;
        end
        @(negedge clk);
        point_valid <= 1'b1;
        x           <= CW'(px);
        y           <= CW'(py);
        z           <= CW'(pz);
        last_point  <= last;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        points_sent++;
    endtask

    // all words out, then room for a point that makes no word
    task automatic settle();
        @(negedge clk);
        point_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_limit(input logic [CFG_INDEX_W-1:0] idx);
        int sel;
        sel = $urandom_range(0, 3);
        if (sel == 0)
            return '0;
        if (sel == 3)
            return rand_word();
        case (idx)
            REG_EDGE_LIMIT:
                return (sel == 1) ? CFG_DATA_W'($urandom_range(0, 16))
                                  : CFG_DATA_W'($urandom_range(0, 200000));
            REG_NORMAL_LIMIT:
                return (sel == 1) ? 63'($urandom_range(0, 4096))
                                  : 63'($urandom) << $urandom_range(0, 28);
            default:
                return (sel == 1) ? 63'($urandom_range(0, 256))
                                  : 63'($urandom) << $urandom_range(0, 16);
        endcase
    endfunction

    task automatic program_limits(input int phase);
        if (phase == ZERO_PHASE)
        begin
            write_limit(REG_EDGE_LIMIT, '0);
            write_limit(REG_NORMAL_LIMIT, '0);
            write_limit(REG_PLANE_LIMIT, '0);
        end
        else if (phase == FULL_PHASE)
        begin
            write_limit(REG_EDGE_LIMIT, '1);
            write_limit(REG_NORMAL_LIMIT, '1);
            write_limit(REG_PLANE_LIMIT, '1);
        end
        else
        begin
            write_limit(REG_EDGE_LIMIT, pick_limit(REG_EDGE_LIMIT));
            write_limit(REG_NORMAL_LIMIT, pick_limit(REG_NORMAL_LIMIT));
            write_limit(REG_PLANE_LIMIT, pick_limit(REG_PLANE_LIMIT));
        end
        write_limit(REG_SPARE, rand_word());
    endtask

    task automatic directed_sets();
        // lone point
        send_point(0, 0, 0, 1'b1);
        // full-scale corners, squared cross sum runs past 64 bits
        send_point(-32768, -32768, -32768, 1'b0);
        send_point(32767, -32768, -32768, 1'b0);
        send_point(-32768, 32767, 32767, 1'b0);
        send_point(32767, 32767, -32768, 1'b1);
        // two points, no normal
        send_point(100, -200, 300, 1'b0);
        send_point(-100, 200, -300, 1'b1);
        // flat square
        send_point(0, 0, 0, 1'b0);
        send_point(256, 0, 0, 1'b0);
        send_point(0, 256, 0, 1'b0);
        send_point(256, 256, 0, 1'b1);
        // unit cube corner, then a point after the flag is up
        send_point(0, 0, 0, 1'b0);
        send_point(256, 0, 0, 1'b0);
        send_point(0, 256, 0, 1'b0);
        send_point(0, 0, 256, 1'b0);
        send_point(256, 256, 256, 1'b1);
        // coincident points
        send_point(5, 5, 5, 1'b0);
        send_point(5, 5, 5, 1'b0);
        send_point(5, 5, 5, 1'b1);
        // collinear points
        send_point(0, 0, 0, 1'b0);
        send_point(1, 1, 1, 1'b0);
        send_point(2, 2, 2, 1'b0);
        send_point(3, 3, 3, 1'b1);
    endtask

    task automatic random_sets(input int count);
        int start, sel, n, k, a, b, bent, axis;
        int ox, oy, oz, ux, uy, uz, vx, vy, vz;
        int qx [$];
        int qy [$];
        int qz [$];
        start = points_sent;
        while (points_sent - start < count)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            qx.delete();
            qy.delete();
            qz.delete();
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                // stray word, may leave a set open across the next one
                send_point($urandom, $urandom, $urandom, $urandom_range(0, 5) == 0);
            end
            else if (sel <= 7)
            begin
                ox = srand(12000);
                oy = srand(12000);
                oz = srand(12000);
                ux = srand(150);
                uy = srand(150);
                uz = srand(150);
                vx = srand(150);
                vy = srand(150);
                vz = srand(150);
                qx = {qx, ox};
                qy = {qy, oy};
                qz = {qz, oz};
                k = $urandom_range(0, 2);
                repeat (k)
                begin
                    qx = {qx, ox + srand(2)};
                    qy = {qy, oy + srand(2)};
                    qz = {qz, oz + srand(2)};
                end
                k = $urandom_range(0, 2);
                repeat (k)
                begin
                    a = srand(20);
                    qx = {qx, ox + a * ux};
                    qy = {qy, oy + a * uy};
                    qz = {qz, oz + a * uz};
                end
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    a = srand(20);
                    b = srand(20);
                    qx = {qx, ox + a * ux + b * vx};
                    qy = {qy, oy + a * uy + b * vy};
                    qz = {qz, oz + a * uz + b * vz};
                end
                // nudge one point just off the plane
                if ($urandom_range(0, 9) < 3)
                begin
                    bent = $urandom_range(1, qx.size() - 1);
                    axis = $urandom_range(0, 2);
                    if (axis == 0)
                        qx[bent] += srand(4);
                    else if (axis == 1)
                        qy[bent] += srand(4);
                    else
                        qz[bent] += srand(4);
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    qx = {qx, int'($urandom)};
                    qy = {qy, int'($urandom)};
                    qz = {qz, int'($urandom)};
                end
                for (int i = 0; i < qx.size(); i++)
                    send_point(qx[i], qy[i], qz[i], i == qx.size() - 1);
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_point($urandom, $urandom, $urandom, i == n - 1);
            end
        end
        quiet = 1'b0;
        send_point($urandom, $urandom, $urandom, 1'b1);
    endtask

    initial
    begin
        int hold_done, sel, n;
        hold_done    = 0;
        result_stall = 1'b0;
        forever
        begin
            if (hold_req != hold_done)
            begin
                // long hold-off: the block backs up and stalls its input
                hold_done = hold_req;
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                    result_stall <= 1'b1;
                end
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 25)
                begin
                    n = $urandom_range(20, 80);
                    repeat (n)
                    begin
                        @(negedge clk);
                        result_stall <= 1'b0;
                    end
                end
                else if (sel < 90)
                begin
                    @(negedge clk);
                    result_stall <= ($urandom_range(0, 2) == 0);
                end
                else
                begin
                    n = $urandom_range(5, 40);
                    repeat (n)
                    begin
                        @(negedge clk);
                        result_stall <= 1'b1;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        point_valid = 1'b0;
        x           = '0;
        y           = '0;
        z           = '0;
        last_point  = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_sets();
        settle();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            program_limits(phase);
            if (phase == 2 || phase == 5)
                hold_req++;
            random_sets(PHASE_POINTS);
            settle();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[point_set_volume_test.f]
+incdir+rtl
rtl/psv_pkg.sv
rtl/point_set_volume_test.sv
dv/point_set_volume_checker.sv
dv/tb_point_set_volume_test.sv
